// ===== design/gain_and_linear_resampler_unit_defines.svh =====
// Assertion macros shared by the resampler RTL
`ifndef GAIN_AND_LINEAR_RESAMPLER_UNIT_DEFINES_SVH
`define GAIN_AND_LINEAR_RESAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define GLRU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GLRU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/glru_pkg.sv =====
// Types and constants for the gain and linear resampler
package glru_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int VOL_W       = 7;
  localparam int STEP_W      = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int GAIN_W      = 21;
  localparam int GAIN_DEN_W  = 22;

  // 127 cubed
  localparam logic [GAIN_DEN_W-1:0] GAIN_DEN = 22'd2048383;

  localparam logic [CFG_INDEX_W-1:0] REG_PROG_GAIN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_GAIN  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAY_GAIN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_STEP = 2'd3;

  localparam logic [VOL_W-1:0] VOL_RESET = 7'd127;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== design/gain_and_linear_resampler_unit.sv =====
// Gain and linear-interpolation resampler, top level
//
//   channel  direction  handshake         payload
//   in       sink       in_valid/ready    in_item_t  (in_sample, in_last)
//   out      source     out_valid/ready   out_item_t (out_sample, out_last)
//   cfg      sink       cfg_write         cfg_index, cfg_data
//
// An accepted input passes through the serial gain unit (two volume multiplies,
// 16 shift-add steps, 16 restoring divide steps and a done state) before any output.
// Each interpolated output passes through the serial interpolator, and each flush
// output is registered straight from the held sample; an out_ready stall holds either.
// Synchronous reset restores volumes to 127, step to 1.0 and clears clip state.
// in_ready is high only between input transactions.
`include "gain_and_linear_resampler_unit_defines.svh"

module gain_and_linear_resampler_unit
  import glru_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 2;
  localparam logic [POS_W-1:0] ONE      = POS_W'(1) << PHASE_FRAC_BITS;
  localparam logic [POS_W-1:0] TWO      = ONE << 1;
  localparam logic [POS_W-1:0] MIN_STEP = POS_W'(1) << (PHASE_FRAC_BITS - 4);
  localparam logic [STEP_W-1:0] STEP_RESET = ONE[STEP_W-1:0];

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GAIN   = 3'd1;
  localparam logic [2:0] S_ILOOP  = 3'd2;
  localparam logic [2:0] S_INTERP = 3'd3;
  localparam logic [2:0] S_OUT_I  = 3'd4;
  localparam logic [2:0] S_FLOOP  = 3'd5;
  localparam logic [2:0] S_OUT_F  = 3'd6;

  logic [2:0]                 state;
  logic [VOL_W-1:0]           prog_gain;
  logic [VOL_W-1:0]           tone_gain;
  logic [VOL_W-1:0]           play_gain;
  logic [STEP_W-1:0]          pitch_step;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic                       have_previous;
  logic [POS_W-1:0]           pos;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic                       last_item;
  logic                       mark_last;

  logic [POS_W-1:0]           step_ext;
  logic [POS_W-1:0]           step_eff;
  logic [POS_W-1:0]           pos_adv;
  logic                       pos_below_one;
  logic                       gain_start;
  logic                       interp_start;
  unit_status_t               gain_st;
  unit_status_t               interp_st;
  logic signed [SAMPLE_W-1:0] gained;
  logic signed [SAMPLE_W-1:0] interp_result;

  always_comb begin
    step_ext      = POS_W'(pitch_step);
    step_eff      = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
    pos_adv       = pos + step_eff;
    pos_below_one = pos < ONE;
  end

  assign in_ready     = state == S_IDLE;
  assign out_valid    = (state == S_OUT_I) || (state == S_OUT_F);
  assign gain_start   = (state == S_IDLE) && in_valid;
  assign interp_start = (state == S_ILOOP) && pos_below_one;

  glru_gain u_gain (
    .clk    (clk),
    .rst    (rst),
    .start  (gain_start),
    .sample (in_data.in_sample),
    .vol_a  (prog_gain),
    .vol_b  (tone_gain),
    .vol_c  (play_gain),
    .status (gain_st),
    .gained (gained)
  );

  glru_interp #(
    .FRAC_BITS (PHASE_FRAC_BITS)
  ) u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (interp_start),
    .a      (previous_sample),
    .b      (cur_sample),
    .frac   (pos[PHASE_FRAC_BITS-1:0]),
    .status (interp_st),
    .result (interp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      prog_gain       <= VOL_RESET;
      tone_gain       <= VOL_RESET;
      play_gain       <= VOL_RESET;
      pitch_step      <= STEP_RESET;
      previous_sample <= '0;
      have_previous   <= 1'b0;
      pos             <= '0;
      last_item       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PROG_GAIN:  prog_gain  <= cfg_data[VOL_W-1:0];
          REG_TONE_GAIN:  tone_gain  <= cfg_data[VOL_W-1:0];
          REG_PLAY_GAIN:  play_gain  <= cfg_data[VOL_W-1:0];
          REG_PITCH_STEP: pitch_step <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_item <= in_data.in_last;
            state     <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (gain_st.done) begin
            cur_sample <= gained;
            if (have_previous) begin
              state <= S_ILOOP;
            end else begin
              previous_sample <= gained;
              have_previous   <= 1'b1;
              state           <= last_item ? S_FLOOP : S_IDLE;
            end
          end
        end
        S_ILOOP: begin
          if (pos_below_one) begin
            mark_last <= last_item && (pos_adv >= TWO);
            pos       <= pos_adv;
            state     <= S_INTERP;
          end else begin
            pos             <= pos - ONE;
            previous_sample <= cur_sample;
            have_previous   <= 1'b1;
            state           <= last_item ? S_FLOOP : S_IDLE;
          end
        end
        S_INTERP: begin
          if (interp_st.done) begin
            out_data.out_sample <= interp_result;
            out_data.out_last   <= mark_last;
            state               <= S_OUT_I;
          end
        end
        S_OUT_I: begin
          if (out_ready) state <= S_ILOOP;
        end
        S_FLOOP: begin
          if (pos_below_one) begin
            out_data.out_sample <= cur_sample;
            out_data.out_last   <= pos_adv >= ONE;
            pos                 <= pos_adv;
            state               <= S_OUT_F;
          end else begin
            // end of clip: next transaction starts a fresh clip
            pos             <= '0;
            previous_sample <= '0;
            have_previous   <= 1'b0;
            state           <= S_IDLE;
          end
        end
        S_OUT_F: begin
          if (out_ready) state <= S_FLOOP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GLRU_ASSERT_IMP(a_idle_units_quiet, clk, rst, state == S_IDLE, !gain_st.busy && !interp_st.busy, "serial unit busy while idle")
  `GLRU_ASSERT_IMP(a_gain_done_owner, clk, rst, gain_st.done, state == S_GAIN, "gain result outside gain wait")
  `GLRU_ASSERT_IMP(a_interp_done_owner, clk, rst, interp_st.done, state == S_INTERP, "interpolation result unexpected")
  `GLRU_ASSERT_IMP(a_last_needs_last_in, clk, rst, out_valid && out_data.out_last, last_item, "last output without last input")
  `GLRU_ASSERT_NXT(a_clip_end_clears, clk, rst, (state == S_FLOOP) && !pos_below_one, !have_previous && (pos == '0), "clip state not cleared")

endmodule

// ===== design/glru_gain.sv =====
// Bit-serial gain: sample times three volumes, divided by 127 cubed toward zero
module glru_gain
  import glru_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [VOL_W-1:0]           vol_a,
  input  logic [VOL_W-1:0]           vol_b,
  input  logic [VOL_W-1:0]           vol_c,
  output unit_status_t               status,
  output logic signed [SAMPLE_W-1:0] gained
);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_VOL1 = 3'd1;
  localparam logic [2:0] G_VOL2 = 3'd2;
  localparam logic [2:0] G_MUL  = 3'd3;
  localparam logic [2:0] G_DIV  = 3'd4;
  localparam logic [2:0] G_DONE = 3'd5;

  logic [2:0]            state;
  logic                  neg;
  logic [SAMPLE_W-1:0]   mplier;
  logic [GAIN_W-1:0]     num;
  logic [GAIN_W-1:0]     prod_hi;
  logic [SAMPLE_W-1:0]   prod_lo;
  logic [3:0]            cnt;

  logic [SAMPLE_W-1:0]   sample_u;
  logic [2*VOL_W-1:0]    vol_ab;
  logic [GAIN_W-1:0]     vol_abc;
  logic [GAIN_W:0]       mul_sum;
  logic [GAIN_DEN_W-1:0] trial;
  logic                  trial_ge;
  logic [GAIN_DEN_W-1:0] trial_sub;

  always_comb begin
    sample_u  = sample;
    vol_ab    = vol_a * vol_b;
    vol_abc   = num[2*VOL_W-1:0] * vol_c;
    mul_sum   = {1'b0, prod_hi} + (mplier[0] ? {1'b0, num} : '0);
    trial     = {prod_hi, prod_lo[SAMPLE_W-1]};
    trial_ge  = trial >= GAIN_DEN;
    trial_sub = trial - GAIN_DEN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        G_IDLE: begin
          if (start) begin
            neg    <= sample[SAMPLE_W-1];
            mplier <= sample[SAMPLE_W-1] ? (~sample_u + 16'd1) : sample_u;
            state  <= G_VOL1;
          end
        end
        G_VOL1: begin
          num   <= GAIN_W'(vol_ab);
          state <= G_VOL2;
        end
        G_VOL2: begin
          num     <= vol_abc;
          prod_hi <= '0;
          cnt     <= '0;
          state   <= G_MUL;
        end
        G_MUL: begin
          prod_hi <= mul_sum[GAIN_W:1];
          prod_lo <= {mul_sum[0], prod_lo[SAMPLE_W-1:1]};
          mplier  <= {1'b0, mplier[SAMPLE_W-1:1]};
          cnt     <= cnt + 4'd1;
          if (cnt == 4'd15) state <= G_DIV;
        end
        G_DIV: begin
          prod_hi <= trial_ge ? trial_sub[GAIN_W-1:0] : trial[GAIN_W-1:0];
          prod_lo <= {prod_lo[SAMPLE_W-2:0], trial_ge};
          cnt     <= cnt + 4'd1;
          if (cnt == 4'd15) state <= G_DONE;
        end
        G_DONE: state <= G_IDLE;
        default: state <= G_IDLE;
      endcase
    end
  end

  // quotient sits in prod_lo once division completes
  assign gained      = neg ? (~prod_lo + 16'd1) : prod_lo;
  assign status.busy = state != G_IDLE;
  assign status.done = state == G_DONE;

endmodule

// ===== design/glru_interp.sv =====
// Bit-serial linear interpolation with round half away from zero
module glru_interp
  import glru_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  input  logic [FRAC_BITS-1:0]       frac,
  output unit_status_t               status,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  localparam logic [1:0] I_IDLE = 2'd0;
  localparam logic [1:0] I_MUL  = 2'd1;
  localparam logic [1:0] I_RND  = 2'd2;
  localparam logic [1:0] I_DONE = 2'd3;

  logic [1:0]                 state;
  logic signed [SAMPLE_W-1:0] a_reg;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W:0]   hi;
  logic [FRAC_BITS-1:0]       lo;
  logic [FRAC_BITS-1:0]       fr;
  logic [CNT_W-1:0]           cnt;

  logic [SAMPLE_W+1:0]        step_sum;
  logic [SAMPLE_W+1:0]        hsum;
  logic                       inc;
  logic [SAMPLE_W+1:0]        rnd;

  always_comb begin
    step_sum = {hi[SAMPLE_W], hi} + (fr[0] ? {diff[SAMPLE_W], diff} : '0);
    hsum     = {{2{a_reg[SAMPLE_W-1]}}, a_reg} + {hi[SAMPLE_W], hi};
    inc      = hsum[SAMPLE_W+1] ? (lo[FRAC_BITS-1] & (|lo[FRAC_BITS-2:0]))
                                : lo[FRAC_BITS-1];
    rnd      = hsum + {{(SAMPLE_W+1){1'b0}}, inc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        I_IDLE: begin
          if (start) begin
            a_reg <= a;
            diff  <= {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
            hi    <= '0;
            fr    <= frac;
            cnt   <= '0;
            state <= I_MUL;
          end
        end
        I_MUL: begin
          hi    <= step_sum[SAMPLE_W+1:1];
          lo    <= {step_sum[0], lo[FRAC_BITS-1:1]};
          fr    <= {1'b0, fr[FRAC_BITS-1:1]};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_BITS - 1)) state <= I_RND;
        end
        I_RND: begin
          result <= rnd[SAMPLE_W-1:0];
          state  <= I_DONE;
        end
        I_DONE: state <= I_IDLE;
        default: state <= I_IDLE;
      endcase
    end
  end

  assign status.busy = state != I_IDLE;
  assign status.done = state == I_DONE;

endmodule
